>>> rtl/sorted_min_priority_queue_macros.svh
// ---------------------------------------------------------------------------
// Sorted minimum priority queue: assertion macros
// Checks are compiled for simulation only and expand to nothing otherwise.
// ---------------------------------------------------------------------------
`ifndef SORTED_MIN_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_MIN_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold on every clock edge out of reset
`define SMPQ_ASSERT(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Same-cycle implication
`define SMPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define SMPQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define SMPQ_ASSERT(lbl, clk, rstn, expr, msg)
`define SMPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define SMPQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/smpq_pkg.sv
// ---------------------------------------------------------------------------
// Sorted minimum priority queue: shared types
// Operation kinds, result status codes and the cell command.
// ---------------------------------------------------------------------------
package smpq_pkg;

	// Operation selector carried on the input tuser
	typedef enum logic [1:0] {
		KIND_INSERT  = 2'd0,
		KIND_EXTRACT = 2'd1,
		KIND_SEARCH  = 2'd2
	} kind_t;

	// Result status carried on the output tuser
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_EMPTY     = 2'd1,
		STATUS_FULL      = 2'd2,
		STATUS_NOT_FOUND = 2'd3
	} status_t;

	// Command broadcast to every cell of the chain
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_SHIFT  = 2'd2,
		CELL_ROTATE = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     last_fill;
	} cell_ctl_t;

endpackage

>>> rtl/sorted_min_priority_queue.sv
// Sorted minimum priority queue of map nodes, built as a chain of DEPTH cells
// kept in priority order with the minimum in cell 0. Insert and extract act on
// the whole chain at once: every cell compares against the new priority locally
// and the whole chain shifts in parallel, so such an item is accepted every
// cycle while the result register drains and no search is running. A search
// rotates the chain once around the ring and checks cell 0 on each step, so it
// holds off the input until the rotation is done, and it leaves the order
// unchanged. Equal priorities leave in insertion order. Each input transfer
// gives exactly one result transfer with the status, the hit entry, the minimum
// priority, the count and the empty flag after the operation.

// ---------------------------------------------------------------------------
// Sorted minimum priority queue: top level
// Stream ports, control sequencer, result register and the cell chain.
// ---------------------------------------------------------------------------
`include "sorted_min_priority_queue_macros.svh"

module sorted_min_priority_queue #(
	parameter int DEPTH      = 64,
	parameter int COORD_BITS = 10,
	parameter int PRIO_BITS  = 24
) (
	input  logic clk,
	input  logic arst_n,
	// Input stream
	input  logic s_tvalid,
	output logic s_tready,
	// node_x, node_y, priority_req
	input  logic [((2*COORD_BITS+PRIO_BITS+7)/8)*8-1:0] s_tdata,
	// kind
	input  logic [1:0] s_tuser,
	// Result stream
	output logic m_tvalid,
	input  logic m_tready,
	// hit_x, hit_y, hit_priority, head_priority, entry_count, is_empty
	output logic [((2*COORD_BITS+2*PRIO_BITS+$clog2(DEPTH+1)+1+7)/8)*8-1:0] m_tdata,
	// status
	output logic [1:0] m_tuser
);

	localparam int IDXW    = $clog2(DEPTH);
	localparam int CNTW    = $clog2(DEPTH+1);
	localparam int OUT_RAW = 2*COORD_BITS + 2*PRIO_BITS + CNTW + 1;
	localparam int OUT_W   = ((OUT_RAW+7)/8)*8;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	state_t                 state_q;
	logic [IDXW-1:0]        step_q;
	logic [CNTW-1:0]        count_q;
	logic                   found_q;
	logic [COORD_BITS-1:0]  key_x_q;
	logic [COORD_BITS-1:0]  key_y_q;

	logic                   out_valid_q;
	smpq_pkg::status_t      out_status_q;
	logic [COORD_BITS-1:0]  hit_x_q;
	logic [COORD_BITS-1:0]  hit_y_q;
	logic [PRIO_BITS-1:0]   hit_prio_q;
	logic [PRIO_BITS-1:0]   head_q;
	logic [CNTW-1:0]        out_count_q;
	logic                   out_empty_q;

	logic                   in_fire;
	smpq_pkg::kind_t        in_kind;
	logic [COORD_BITS-1:0]  in_x;
	logic [COORD_BITS-1:0]  in_y;
	logic [PRIO_BITS-1:0]   in_prio;
	logic                   full;
	logic                   last_step;
	logic                   head_match;
	smpq_pkg::cell_ctl_t    ctl;

	logic [DEPTH-1:0]       cell_valid;
	logic [DEPTH-1:0]       cell_take;
	logic [COORD_BITS-1:0]  cell_x    [DEPTH];
	logic [COORD_BITS-1:0]  cell_y    [DEPTH];
	logic [PRIO_BITS-1:0]   cell_prio [DEPTH];
	logic [PRIO_BITS-1:0]   head_now;

	// Input unpacking
	assign in_kind = smpq_pkg::kind_t'(s_tuser);
	assign in_x    = s_tdata[COORD_BITS-1:0];
	assign in_y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign in_prio = s_tdata[2*COORD_BITS+PRIO_BITS-1:2*COORD_BITS];

	// Handshake: take an item only when idle and the result slot frees up
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign in_fire  = s_tvalid && s_tready;

	assign full       = (count_q == CNTW'(DEPTH));
	assign last_step  = (step_q == IDXW'(DEPTH-1));
	assign head_match = cell_valid[0] && (cell_x[0] == key_x_q) && (cell_y[0] == key_y_q);
	assign head_now   = cell_valid[0] ? cell_prio[0] : '0;

	// Chain command
	always_comb begin
		ctl.op        = smpq_pkg::CELL_HOLD;
		ctl.last_fill = 1'b0;
		if (state_q == ST_SEARCH) begin
			ctl.op        = smpq_pkg::CELL_ROTATE;
			ctl.last_fill = 1'b1;
		end else if (in_fire) begin
			case (in_kind)
				smpq_pkg::KIND_INSERT: begin
					if (!full) begin
						ctl.op = smpq_pkg::CELL_INSERT;
					end
				end
				smpq_pkg::KIND_EXTRACT: begin
					if (count_q != '0) begin
						ctl.op = smpq_pkg::CELL_SHIFT;
					end
				end
				default: begin
					ctl.op = smpq_pkg::CELL_HOLD;
				end
			endcase
		end
	end

	// Cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  prv_valid;
		logic [COORD_BITS-1:0] prv_x;
		logic [COORD_BITS-1:0] prv_y;
		logic [PRIO_BITS-1:0]  prv_prio;
		logic                  prv_take;
		logic                  nxt_valid;
		logic [COORD_BITS-1:0] nxt_x;
		logic [COORD_BITS-1:0] nxt_y;
		logic [PRIO_BITS-1:0]  nxt_prio;

		if (i == 0) begin : g_first
			assign prv_valid = 1'b0;
			assign prv_x     = '0;
			assign prv_y     = '0;
			assign prv_prio  = '0;
			assign prv_take  = 1'b0;
		end else begin : g_mid
			assign prv_valid = cell_valid[i-1];
			assign prv_x     = cell_x[i-1];
			assign prv_y     = cell_y[i-1];
			assign prv_prio  = cell_prio[i-1];
			assign prv_take  = cell_take[i-1];
		end

		// Last cell closes the ring on rotate and empties on extract
		if (i == DEPTH-1) begin : g_last
			assign nxt_valid = ctl.last_fill && cell_valid[0];
			assign nxt_x     = cell_x[0];
			assign nxt_y     = cell_y[0];
			assign nxt_prio  = cell_prio[0];
		end else begin : g_inner
			assign nxt_valid = cell_valid[i+1];
			assign nxt_x     = cell_x[i+1];
			assign nxt_y     = cell_y[i+1];
			assign nxt_prio  = cell_prio[i+1];
		end

		smpq_cell #(
			.COORD_BITS(COORD_BITS),
			.PRIO_BITS (PRIO_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.new_x    (in_x),
			.new_y    (in_y),
			.new_prio (in_prio),
			.prv_valid(prv_valid),
			.prv_x    (prv_x),
			.prv_y    (prv_y),
			.prv_prio (prv_prio),
			.prv_take (prv_take),
			.nxt_valid(nxt_valid),
			.nxt_x    (nxt_x),
			.nxt_y    (nxt_y),
			.nxt_prio (nxt_prio),
			.valid    (cell_valid[i]),
			.x        (cell_x[i]),
			.y        (cell_y[i]),
			.prio     (cell_prio[i]),
			.take     (cell_take[i])
		);
	end

	// Sequencer, fill count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			count_q      <= '0;
			found_q      <= 1'b0;
			key_x_q      <= '0;
			key_y_q      <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= smpq_pkg::STATUS_OK;
			hit_x_q      <= '0;
			hit_y_q      <= '0;
			hit_prio_q   <= '0;
			head_q       <= '0;
			out_count_q  <= '0;
			out_empty_q  <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (out_valid_q && m_tready) begin
						out_valid_q <= 1'b0;
					end
					if (in_fire) begin
						hit_x_q      <= '0;
						hit_y_q      <= '0;
						hit_prio_q   <= '0;
						out_status_q <= smpq_pkg::STATUS_OK;
						head_q       <= head_now;
						out_count_q  <= count_q;
						out_empty_q  <= (count_q == '0);
						out_valid_q  <= 1'b1;
						case (in_kind)
							smpq_pkg::KIND_INSERT: begin
								if (full) begin
									out_status_q <= smpq_pkg::STATUS_FULL;
								end else begin
									count_q     <= count_q + CNTW'(1);
									out_count_q <= count_q + CNTW'(1);
									out_empty_q <= 1'b0;
									head_q      <= cell_take[0] ? in_prio : cell_prio[0];
								end
							end
							smpq_pkg::KIND_EXTRACT: begin
								if (count_q == '0) begin
									out_status_q <= smpq_pkg::STATUS_EMPTY;
								end else begin
									hit_x_q     <= cell_x[0];
									hit_y_q     <= cell_y[0];
									hit_prio_q  <= cell_prio[0];
									count_q     <= count_q - CNTW'(1);
									out_count_q <= count_q - CNTW'(1);
									out_empty_q <= (count_q == CNTW'(1));
									head_q      <= cell_valid[1] ? cell_prio[1] : '0;
								end
							end
							smpq_pkg::KIND_SEARCH: begin
								out_valid_q <= 1'b0;
								key_x_q     <= in_x;
								key_y_q     <= in_y;
								found_q     <= 1'b0;
								step_q      <= '0;
								state_q     <= ST_SEARCH;
							end
							default: begin
								out_status_q <= smpq_pkg::STATUS_OK;
							end
						endcase
					end
				end
				ST_SEARCH: begin
					// Cell 0 holds the entry at queue position step_q
					if (head_match && !found_q) begin
						found_q    <= 1'b1;
						hit_x_q    <= cell_x[0];
						hit_y_q    <= cell_y[0];
						hit_prio_q <= cell_prio[0];
					end
					step_q <= step_q + IDXW'(1);
					if (last_step) begin
						// Cell 1 moves into cell 0 on this rotate
						out_status_q <= (found_q || head_match) ? smpq_pkg::STATUS_OK :
						                smpq_pkg::STATUS_NOT_FOUND;
						head_q       <= cell_valid[1] ? cell_prio[1] : '0;
						out_count_q  <= count_q;
						out_empty_q  <= (count_q == '0);
						out_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output packing
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = OUT_W'({out_empty_q, out_count_q, head_q, hit_prio_q, hit_y_q, hit_x_q});

	// Check helpers: occupied cells form a prefix and stay sorted
	logic [DEPTH:0]   fill_mask;
	logic [DEPTH-2:0] order_bad;

	assign fill_mask = ((DEPTH+1)'(1) << count_q) - (DEPTH+1)'(1);
	for (genvar j = 0; j < DEPTH-1; j++) begin : g_order
		assign order_bad[j] = cell_valid[j+1] && (cell_prio[j] > cell_prio[j+1]);
	end

	`SMPQ_ASSERT(a_fill_prefix, clk, arst_n, ((state_q == ST_SEARCH) || (cell_valid == fill_mask[DEPTH-1:0])), "occupied cells do not match the fill count")
	`SMPQ_ASSERT(a_sorted, clk, arst_n, ((state_q == ST_SEARCH) || (order_bad == '0)), "cell chain out of priority order")
	`SMPQ_ASSERT(a_count_range, clk, arst_n, (count_q <= CNTW'(DEPTH)), "fill count beyond depth")
	`SMPQ_ASSERT_IMP(a_search_blocks, clk, arst_n, (state_q == ST_SEARCH), (!s_tready && !out_valid_q), "transfer possible during a search")
	`SMPQ_ASSERT_NXT(a_search_count, clk, arst_n, (state_q == ST_SEARCH), ($stable(count_q)), "fill count changed by a search")

endmodule

>>> rtl/smpq_cell.sv
// ---------------------------------------------------------------------------
// Sorted minimum priority queue: one storage cell
// Holds one entry; on insert it keeps, takes the new entry or takes its
// left neighbor; on shift or rotate it takes its right neighbor.
// ---------------------------------------------------------------------------
module smpq_cell #(
	parameter int COORD_BITS = 10,
	parameter int PRIO_BITS  = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  smpq_pkg::cell_ctl_t    ctl,
	input  logic [COORD_BITS-1:0]  new_x,
	input  logic [COORD_BITS-1:0]  new_y,
	input  logic [PRIO_BITS-1:0]   new_prio,
	input  logic                   prv_valid,
	input  logic [COORD_BITS-1:0]  prv_x,
	input  logic [COORD_BITS-1:0]  prv_y,
	input  logic [PRIO_BITS-1:0]   prv_prio,
	input  logic                   prv_take,
	input  logic                   nxt_valid,
	input  logic [COORD_BITS-1:0]  nxt_x,
	input  logic [COORD_BITS-1:0]  nxt_y,
	input  logic [PRIO_BITS-1:0]   nxt_prio,
	output logic                   valid,
	output logic [COORD_BITS-1:0]  x,
	output logic [COORD_BITS-1:0]  y,
	output logic [PRIO_BITS-1:0]   prio,
	output logic                   take
);

	logic                  valid_q;
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;
	logic [PRIO_BITS-1:0]  prio_q;

	// New entry belongs here or further left: empty cell or larger priority
	assign take = !valid_q || (prio_q > new_prio);

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.op)
				smpq_pkg::CELL_INSERT: begin
					if (take) begin
						valid_q <= prv_take ? prv_valid : 1'b1;
					end
				end
				smpq_pkg::CELL_SHIFT,
				smpq_pkg::CELL_ROTATE: begin
					valid_q <= nxt_valid;
				end
				default: begin
					valid_q <= valid_q;
				end
			endcase
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		case (ctl.op)
			smpq_pkg::CELL_INSERT: begin
				if (take && prv_take) begin
					x_q    <= prv_x;
					y_q    <= prv_y;
					prio_q <= prv_prio;
				end else if (take) begin
					x_q    <= new_x;
					y_q    <= new_y;
					prio_q <= new_prio;
				end
			end
			smpq_pkg::CELL_SHIFT,
			smpq_pkg::CELL_ROTATE: begin
				x_q    <= nxt_x;
				y_q    <= nxt_y;
				prio_q <= nxt_prio;
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

	assign valid = valid_q;
	assign x     = x_q;
	assign y     = y_q;
	assign prio  = prio_q;

endmodule
